// ----- src/idl_pkg.sv -----
// shared types and constants for the indexed doubly linked list core
package idl_pkg;

   localparam int TYPE_W   = 3;
   localparam int POS_W    = 11;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // request codes
   typedef enum logic [TYPE_W-1:0] {
      REQ_INS_HEAD  = 3'd0,
      REQ_INS_TAIL  = 3'd1,
      REQ_DELETE    = 3'd2,
      REQ_INS_LEFT  = 3'd3,
      REQ_INS_RIGHT = 3'd4,
      REQ_READ_NEXT = 3'd5
   } req_code_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_BAD_POS = 2'd2
   } status_code_type;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_UNLINK,
      OP_ANCHOR_LEFT,
      OP_ANCHOR_ENTRY,
      OP_PLACE,
      OP_LINK,
      OP_STEP,
      OP_FETCH
   } dp_op_type;

   typedef struct packed {
      dp_op_type       op;
      logic            load_rsp;
      status_code_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic pos_ok;
      logic live;
      logic at_tail;
   } flags_type;

endpackage

// ----- src/idl_ram.sv -----
// generic single write port ram with registered read
module idl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1026
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- src/idl_ctrl.sv -----
// sequencing state machine for the list core
module idl_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [idl_pkg::TYPE_W-1:0]         req_type,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  idl_pkg::flags_type                 flags,
   output idl_pkg::cmd_type                   cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_AFTER,
      S_LINK,
      S_STEP,
      S_FETCH,
      S_DONE
   } state_type;

   state_type                state_ff;
   idl_pkg::req_code_type    op_ff;
   idl_pkg::status_code_type status_ff;
   logic                     rsp_valid_ff;
   logic                     accept;
   logic                     rsp_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // command decode per state
   always_comb begin
      cmd.op         = idl_pkg::OP_NONE;
      cmd.load_rsp   = 1'b0;
      cmd.rsp_status = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.op = idl_pkg::OP_ACCEPT;
            end
         end
         S_CHECK: begin
            if (flags.live) begin
               case (op_ff)
                  idl_pkg::REQ_DELETE: cmd.op = idl_pkg::OP_UNLINK;
                  idl_pkg::REQ_INS_LEFT: begin
                     if (!flags.full) cmd.op = idl_pkg::OP_ANCHOR_LEFT;
                  end
                  idl_pkg::REQ_INS_RIGHT: begin
                     if (!flags.full) cmd.op = idl_pkg::OP_ANCHOR_ENTRY;
                  end
                  default: cmd.op = idl_pkg::OP_NONE;
               endcase
            end
         end
         S_AFTER: cmd.op = idl_pkg::OP_PLACE;
         S_LINK:  cmd.op = idl_pkg::OP_LINK;
         S_STEP:  cmd.op = idl_pkg::OP_STEP;
         S_FETCH: cmd.op = idl_pkg::OP_FETCH;
         S_DONE:  cmd.load_rsp = rsp_free;
         default: cmd.op = idl_pkg::OP_NONE;
      endcase
   end

   // state, request code, status and result beat valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= idl_pkg::REQ_INS_HEAD;
         status_ff    <= idl_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff <= idl_pkg::req_code_type'(req_type);
                  case (idl_pkg::req_code_type'(req_type))
                     idl_pkg::REQ_INS_HEAD, idl_pkg::REQ_INS_TAIL: begin
                        if (flags.full) begin
                           status_ff <= idl_pkg::ST_FULL;
                           state_ff  <= S_DONE;
                        end else begin
                           status_ff <= idl_pkg::ST_OK;
                           state_ff  <= S_AFTER;
                        end
                     end
                     idl_pkg::REQ_DELETE, idl_pkg::REQ_INS_LEFT,
                     idl_pkg::REQ_INS_RIGHT: begin
                        if (flags.pos_ok) begin
                           status_ff <= idl_pkg::ST_OK;
                           state_ff  <= S_CHECK;
                        end else begin
                           status_ff <= idl_pkg::ST_BAD_POS;
                           state_ff  <= S_DONE;
                        end
                     end
                     idl_pkg::REQ_READ_NEXT: begin
                        status_ff <= idl_pkg::ST_OK;
                        state_ff  <= S_STEP;
                     end
                     default: begin
                        status_ff <= idl_pkg::ST_OK;
                        state_ff  <= S_DONE;
                     end
                  endcase
               end
            end
            S_CHECK: begin
               if (!flags.live) begin
                  status_ff <= idl_pkg::ST_BAD_POS;
                  state_ff  <= S_DONE;
               end else if (op_ff == idl_pkg::REQ_DELETE) begin
                  state_ff <= S_DONE;
               end else if (flags.full) begin
                  status_ff <= idl_pkg::ST_FULL;
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= S_AFTER;
               end
            end
            S_AFTER: state_ff <= S_LINK;
            S_LINK:  state_ff <= S_DONE;
            S_STEP:  state_ff <= flags.at_tail ? S_DONE : S_FETCH;
            S_FETCH: state_ff <= S_DONE;
            S_DONE: begin
               if (rsp_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // an accepted request always leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("request accepted but controller stayed idle");

   // linking finishes the insert
   a_link_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LINK |=> state_ff == S_DONE)
      else $error("link step not followed by completion");

   // a new result beat comes only out of the completion state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result beat raised outside completion");

endmodule

// ----- src/idl_datapath.sv -----
// link memories, sentinel links, cursor and result registers
module idl_datapath #(
   parameter int CAPACITY = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [idl_pkg::TYPE_W-1:0]         req_type,
   input  logic [idl_pkg::POS_W-1:0]          req_position,
   input  logic signed [idl_pkg::VALUE_W-1:0] req_item_value,
   input  idl_pkg::cmd_type                   cmd,
   output idl_pkg::flags_type                 flags,
   output logic [idl_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [idl_pkg::VALUE_W-1:0] rsp_read_value,
   output logic                               rsp_list_end,
   output logic [idl_pkg::POS_W-1:0]          rsp_new_position
);

   localparam int SLOTS  = CAPACITY + 2;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int CMP_W  = (CNT_W > idl_pkg::POS_W + 1) ? CNT_W : idl_pkg::POS_W + 1;
   localparam logic [SLOT_W-1:0] HEAD = '0;
   localparam logic [SLOT_W-1:0] TAIL = SLOT_W'(1);
   localparam int VW = idl_pkg::VALUE_W;

   // control state
   logic [CNT_W-1:0]  next_slot_ff, next_slot_in;
   logic [SLOT_W-1:0] cursor_ff, cursor_in;
   logic [SLOT_W-1:0] head_right_ff, head_right_in;
   logic [SLOT_W-1:0] tail_left_ff, tail_left_in;
   logic              rd_head_ff, rd_head_in;

   // payload registers
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [VW-1:0]            value_ff, value_in;
   logic [SLOT_W-1:0]        anchor_ff, anchor_in;
   logic [SLOT_W-1:0]        after_ff, after_in;
   logic [VW-1:0]            res_value_ff, res_value_in;
   logic                     res_end_ff, res_end_in;
   logic [idl_pkg::POS_W-1:0] res_newpos_ff, res_newpos_in;
   logic [idl_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [VW-1:0]            rsp_value_ff;
   logic                     rsp_end_ff;
   logic [idl_pkg::POS_W-1:0] rsp_newpos_ff;

   // memory ports
   logic              val_we, left_we, right_we, live_we;
   logic [SLOT_W-1:0] val_waddr, left_waddr, right_waddr, live_waddr;
   logic [SLOT_W-1:0] val_raddr, left_raddr, right_raddr, live_raddr;
   logic [VW-1:0]     val_wdata, val_q;
   logic [SLOT_W-1:0] left_wdata, left_q, right_wdata, right_ram_q, right_q;
   logic              live_wdata, live_q;

   // request decode
   idl_pkg::req_code_type req_code;
   logic [SLOT_W-1:0]     req_slot;
   logic [CMP_W-1:0]      pos_plus;
   logic [SLOT_W-1:0]     fresh;

   assign req_code = idl_pkg::req_code_type'(req_type);
   assign pos_plus = CMP_W'(req_position) + CMP_W'(1);
   assign req_slot = pos_plus[SLOT_W-1:0];
   assign fresh    = next_slot_ff[SLOT_W-1:0];
   assign right_q  = rd_head_ff ? head_right_ff : right_ram_q;

   // status towards the controller
   assign flags.full    = (next_slot_ff >= CNT_W'(SLOTS));
   assign flags.pos_ok  = (req_position != '0) && (pos_plus < CMP_W'(next_slot_ff));
   assign flags.live    = live_q;
   assign flags.at_tail = (right_q == TAIL);

   idl_ram #(.WIDTH(VW), .DEPTH(SLOTS)) u_value_ram (
      .clock(clock), .wr_en(val_we), .wr_addr(val_waddr), .wr_data(val_wdata),
      .rd_addr(val_raddr), .rd_data(val_q)
   );

   idl_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_left_ram (
      .clock(clock), .wr_en(left_we), .wr_addr(left_waddr), .wr_data(left_wdata),
      .rd_addr(left_raddr), .rd_data(left_q)
   );

   idl_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_right_ram (
      .clock(clock), .wr_en(right_we), .wr_addr(right_waddr), .wr_data(right_wdata),
      .rd_addr(right_raddr), .rd_data(right_ram_q)
   );

   idl_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_live_ram (
      .clock(clock), .wr_en(live_we), .wr_addr(live_waddr), .wr_data(live_wdata),
      .rd_addr(live_raddr), .rd_data(live_q)
   );

   // operation decode: memory accesses and next register values
   always_comb begin
      next_slot_in  = next_slot_ff;
      cursor_in     = cursor_ff;
      head_right_in = head_right_ff;
      tail_left_in  = tail_left_ff;
      rd_head_in    = rd_head_ff;
      slot_in       = slot_ff;
      value_in      = value_ff;
      anchor_in     = anchor_ff;
      after_in      = after_ff;
      res_value_in  = res_value_ff;
      res_end_in    = res_end_ff;
      res_newpos_in = res_newpos_ff;
      val_we = 1'b0; left_we = 1'b0; right_we = 1'b0; live_we = 1'b0;
      val_waddr   = fresh;
      val_wdata   = value_ff;
      left_waddr  = fresh;
      left_wdata  = anchor_ff;
      right_waddr = fresh;
      right_wdata = right_q;
      live_waddr  = fresh;
      live_wdata  = 1'b1;
      val_raddr   = right_q;
      left_raddr  = slot_ff;
      right_raddr = slot_ff;
      live_raddr  = slot_ff;
      case (cmd.op)
         idl_pkg::OP_ACCEPT: begin
            slot_in       = req_slot;
            value_in      = req_item_value;
            res_value_in  = '0;
            res_end_in    = 1'b0;
            res_newpos_in = '0;
            anchor_in     = (req_code == idl_pkg::REQ_INS_HEAD) ? HEAD : tail_left_ff;
            left_raddr    = req_slot;
            live_raddr    = req_slot;
            case (req_code)
               idl_pkg::REQ_INS_HEAD:  right_raddr = HEAD;
               idl_pkg::REQ_INS_TAIL:  right_raddr = tail_left_ff;
               idl_pkg::REQ_READ_NEXT: right_raddr = cursor_ff;
               default:                right_raddr = req_slot;
            endcase
            rd_head_in = (right_raddr == HEAD);
         end
         idl_pkg::OP_UNLINK: begin
            // bridge the neighbours of the deleted slot
            if (left_q == HEAD) begin
               head_right_in = right_q;
            end else begin
               right_we    = 1'b1;
               right_waddr = left_q;
               right_wdata = right_q;
            end
            if (right_q == TAIL) begin
               tail_left_in = left_q;
            end else begin
               left_we    = 1'b1;
               left_waddr = right_q;
               left_wdata = left_q;
            end
            live_we    = 1'b1;
            live_waddr = slot_ff;
            live_wdata = 1'b0;
            cursor_in  = HEAD;
         end
         idl_pkg::OP_ANCHOR_LEFT, idl_pkg::OP_ANCHOR_ENTRY: begin
            anchor_in   = (cmd.op == idl_pkg::OP_ANCHOR_LEFT) ? left_q : slot_ff;
            right_raddr = anchor_in;
            rd_head_in  = (anchor_in == HEAD);
         end
         idl_pkg::OP_PLACE: begin
            // fill the fresh slot and point it at its neighbours
            after_in = right_q;
            val_we   = 1'b1;
            left_we  = 1'b1;
            right_we = 1'b1;
            live_we  = 1'b1;
         end
         idl_pkg::OP_LINK: begin
            // point the neighbours at the fresh slot
            if (after_ff == TAIL) begin
               tail_left_in = fresh;
            end else begin
               left_we    = 1'b1;
               left_waddr = after_ff;
               left_wdata = fresh;
            end
            if (anchor_ff == HEAD) begin
               head_right_in = fresh;
            end else begin
               right_we    = 1'b1;
               right_waddr = anchor_ff;
               right_wdata = fresh;
            end
            next_slot_in  = next_slot_ff + CNT_W'(1);
            cursor_in     = HEAD;
            res_newpos_in = idl_pkg::POS_W'(next_slot_ff - CNT_W'(1));
         end
         idl_pkg::OP_STEP: begin
            if (right_q == TAIL) begin
               res_end_in = 1'b1;
               cursor_in  = HEAD;
            end else begin
               val_raddr = right_q;
               cursor_in = right_q;
            end
         end
         idl_pkg::OP_FETCH: res_value_in = val_q;
         default: res_value_in = res_value_ff;
      endcase
   end

   // list control state
   always_ff @(posedge clock) begin
      if (reset) begin
         next_slot_ff  <= CNT_W'(2);
         cursor_ff     <= HEAD;
         head_right_ff <= TAIL;
         tail_left_ff  <= HEAD;
         rd_head_ff    <= 1'b0;
      end else begin
         next_slot_ff  <= next_slot_in;
         cursor_ff     <= cursor_in;
         head_right_ff <= head_right_in;
         tail_left_ff  <= tail_left_in;
         rd_head_ff    <= rd_head_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      value_ff      <= value_in;
      anchor_ff     <= anchor_in;
      after_ff      <= after_in;
      res_value_ff  <= res_value_in;
      res_end_ff    <= res_end_in;
      res_newpos_ff <= res_newpos_in;
      if (cmd.load_rsp) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_value_ff  <= res_value_ff;
         rsp_end_ff    <= res_end_ff;
         rsp_newpos_ff <= res_newpos_ff;
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_read_value   = $signed(rsp_value_ff);
   assign rsp_list_end     = rsp_end_ff;
   assign rsp_new_position = rsp_newpos_ff;

   // the fill count never runs past the store
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      next_slot_ff <= CNT_W'(SLOTS))
      else $error("fill count beyond store size");

   // any insert returns the read cursor to the head
   a_cursor_home: assert property (@(posedge clock) disable iff (reset)
      cmd.op == idl_pkg::OP_LINK |=> cursor_ff == HEAD)
      else $error("cursor not reset after insert");

   // head sentinel never links to itself
   a_head_link: assert property (@(posedge clock) disable iff (reset)
      head_right_ff != HEAD)
      else $error("head sentinel links to itself");

endmodule

// ----- src/indexed_doubly_linked_list_core.sv -----
// Indexed doubly linked list core. The list lives in three memories of CAPACITY+2 entries
// (value, left link, right link) plus a one-bit live memory, each with one write port and
// one registered read port; slots 0 and 1 are the head and tail sentinels, whose outer links
// are held in flip-flops. Element k is the k-th value ever inserted and sits in slot k+1.
// Requests are handled one at a time, each as a chain of dependent link reads and writes
// through the link memories, from acceptance to the result in the output register:
//  - an insert at the head or tail reads the anchor's right link, writes the fresh slot,
//    relinks both neighbours and presents the result;
//  - an insert beside k reads k's links and live bit, checks that k is live, reads the
//    anchor's right link and then goes on as an insert at the head or tail;
//  - a delete reads k's links and live bit, then bridges its neighbours;
//  - a read-next reads the cursor's right link, then the value unless it reached the tail;
//  - a request rejected on its position number, an insert at the head or tail into a full
//    store and an unknown request are answered from the checks made at acceptance;
//  - a request rejected on a deleted element, or an insert beside k into a full store,
//    is answered once k's live bit has been read.
// A new request is accepted while the previous result still waits in the output register;
// its own result is then held back until that register is free. Memories need no clearing
// after reset: slots at or beyond the fill count are never used, so the core is ready as
// soon as reset is released.
module indexed_doubly_linked_list_core #(
   parameter int CAPACITY = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [idl_pkg::TYPE_W-1:0]         req_type,
   input  logic [idl_pkg::POS_W-1:0]          req_position,
   input  logic signed [idl_pkg::VALUE_W-1:0] req_item_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [idl_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [idl_pkg::VALUE_W-1:0] rsp_read_value,
   output logic                               rsp_list_end,
   output logic [idl_pkg::POS_W-1:0]          rsp_new_position
);

   idl_pkg::cmd_type   cmd;
   idl_pkg::flags_type flags;

   // sequencer
   idl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   // list storage and result registers
   idl_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_type         (req_type),
      .req_position     (req_position),
      .req_item_value   (req_item_value),
      .cmd              (cmd),
      .flags            (flags),
      .rsp_status       (rsp_status),
      .rsp_read_value   (rsp_read_value),
      .rsp_list_end     (rsp_list_end),
      .rsp_new_position (rsp_new_position)
   );

endmodule

// ----- tb/sv/indexed_doubly_linked_list_core_tb.sv -----
// testbench for the indexed doubly linked list core: random and directed requests, scoreboard
module indexed_doubly_linked_list_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CAPACITY    = 1024;
   localparam int          SLOTS       = CAPACITY + 2;
   localparam int unsigned HEAD_END    = 0;
   localparam int unsigned TAIL_END    = 1;
   localparam int unsigned CYCLE_LIMIT = 500000;

   typedef struct packed {
      idl_pkg::status_code_type           status;
      logic signed [idl_pkg::VALUE_W-1:0] read_value;
      logic                               list_end;
      logic [idl_pkg::POS_W-1:0]          new_position;
   } list_outcome_type;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic [idl_pkg::TYPE_W-1:0]         req_type;
   logic [idl_pkg::POS_W-1:0]          req_position;
   logic signed [idl_pkg::VALUE_W-1:0] req_item_value;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic [idl_pkg::STATUS_W-1:0]       rsp_status;
   logic signed [idl_pkg::VALUE_W-1:0] rsp_read_value;
   logic                               rsp_list_end;
   logic [idl_pkg::POS_W-1:0]          rsp_new_position;

   // mirror of the list held by the core
   logic [idl_pkg::VALUE_W-1:0] slot_value [SLOTS];
   logic [idl_pkg::POS_W-1:0]   prev_slot [SLOTS];
   logic [idl_pkg::POS_W-1:0]   succ_slot [SLOTS];
   bit                          slot_live [SLOTS];
   int unsigned                 fill_slot;
   int unsigned                 walk_slot;

   list_outcome_type pending_outcomes [$];
   int unsigned      mismatches = 0;
   int unsigned      cycle_count = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               stall_request = 0;
   int               stall_left = 0;

   indexed_doubly_linked_list_core #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_list_end    (rsp_list_end),
      .rsp_new_position(rsp_new_position)
   );

   always #4 clock = ~clock;

   // hand out the next slot and hook it in right of anchor
   function automatic int unsigned splice_after(int unsigned anchor,
                                                logic [idl_pkg::VALUE_W-1:0] value);
      int unsigned fresh;
      int unsigned after;
      fresh = fill_slot;
      after = succ_slot[anchor];
      slot_value[fresh]  = value;
      succ_slot[fresh]   = idl_pkg::POS_W'(after);
      prev_slot[fresh]   = idl_pkg::POS_W'(anchor);
      prev_slot[after]   = idl_pkg::POS_W'(fresh);
      succ_slot[anchor]  = idl_pkg::POS_W'(fresh);
      slot_live[fresh]   = 1'b1;
      fill_slot          = fresh + 1;
      walk_slot          = HEAD_END;
      return fresh;
   endfunction

   // slot of element k when it is still in the list, else 0
   function automatic int unsigned live_slot_of(logic [idl_pkg::POS_W-1:0] pos);
      int unsigned k;
      k = pos;
      if (k == 0 || k + 1 >= fill_slot) return 0;
      return slot_live[k + 1] ? k + 1 : 0;
   endfunction

   // update the mirror for one request and give the result it should produce
   function automatic list_outcome_type apply_request(logic [idl_pkg::TYPE_W-1:0] kind,
                                                      logic [idl_pkg::POS_W-1:0] pos,
                                                      logic [idl_pkg::VALUE_W-1:0] value);
      list_outcome_type outcome;
      int unsigned      slot;
      int unsigned      anchor;
      bit               full;
      outcome = '0;
      full = fill_slot >= SLOTS;
      case (kind)
         idl_pkg::REQ_INS_HEAD, idl_pkg::REQ_INS_TAIL: begin
            if (full) begin
               outcome.status = idl_pkg::ST_FULL;
            end else begin
               anchor = (kind == idl_pkg::REQ_INS_HEAD) ? HEAD_END : prev_slot[TAIL_END];
               outcome.new_position = idl_pkg::POS_W'(splice_after(anchor, value) - 1);
            end
         end
         idl_pkg::REQ_DELETE: begin
            slot = live_slot_of(pos);
            if (slot == 0) begin
               outcome.status = idl_pkg::ST_BAD_POS;
            end else begin
               succ_slot[prev_slot[slot]] = succ_slot[slot];
               prev_slot[succ_slot[slot]] = prev_slot[slot];
               slot_live[slot] = 1'b0;
               walk_slot = HEAD_END;
            end
         end
         idl_pkg::REQ_INS_LEFT, idl_pkg::REQ_INS_RIGHT: begin
            // position is checked ahead of the full store
            slot = live_slot_of(pos);
            if (slot == 0) begin
               outcome.status = idl_pkg::ST_BAD_POS;
            end else if (full) begin
               outcome.status = idl_pkg::ST_FULL;
            end else begin
               anchor = (kind == idl_pkg::REQ_INS_LEFT) ? prev_slot[slot] : slot;
               outcome.new_position = idl_pkg::POS_W'(splice_after(anchor, value) - 1);
            end
         end
         idl_pkg::REQ_READ_NEXT: begin
            slot = succ_slot[walk_slot];
            if (slot == TAIL_END) begin
               outcome.list_end = 1'b1;
               walk_slot = HEAD_END;
            end else begin
               outcome.read_value = slot_value[slot];
               walk_slot = slot;
            end
         end
         default: ;
      endcase
      return outcome;
   endfunction

   // mostly a live element, otherwise zero, never handed out, or anything at all
   function automatic logic [idl_pkg::POS_W-1:0] pick_position();
      int unsigned handed;
      int unsigned k;
      handed = fill_slot - 2;
      k = 1;
      if (handed != 0 && $urandom_range(99) < 85) begin
         repeat (8) begin
            k = $urandom_range(handed, 1);
            if (slot_live[k + 1]) return idl_pkg::POS_W'(k);
         end
         return idl_pkg::POS_W'(k);
      end
      case ($urandom_range(2))
         0:       return '0;
         1:       return idl_pkg::POS_W'($urandom_range(2047, handed + 1));
         default: return idl_pkg::POS_W'($urandom);
      endcase
   endfunction

   // offer one beat, with random gaps ahead of it, and predict once it is taken
   task automatic send_request(logic [idl_pkg::TYPE_W-1:0] kind,
                               logic [idl_pkg::POS_W-1:0] pos,
                               logic [idl_pkg::VALUE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_position   <= pos;
      req_item_value <= value;
      do @(posedge clock); while (!req_ready);
      pending_outcomes.push_back(apply_request(kind, pos, value));
   endtask

   task automatic send_random_request(int insert_weight);
      int                         roll;
      logic [idl_pkg::TYPE_W-1:0] kind;
      roll = $urandom_range(99);
      if (roll < insert_weight) begin
         case ($urandom_range(3))
            0:       kind = idl_pkg::REQ_INS_HEAD;
            1:       kind = idl_pkg::REQ_INS_TAIL;
            2:       kind = idl_pkg::REQ_INS_LEFT;
            default: kind = idl_pkg::REQ_INS_RIGHT;
         endcase
      end else if (roll < insert_weight + (100 - insert_weight) * 2 / 5) begin
         kind = idl_pkg::REQ_DELETE;
      end else if (roll < 97) begin
         kind = idl_pkg::REQ_READ_NEXT;
      end else begin
         // any code, the unused ones included
         kind = idl_pkg::TYPE_W'($urandom_range(7));
      end
      send_request(kind, pick_position(), $urandom);
   endtask

   // drop valid and wait for every outstanding result
   task automatic wait_all_returned();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0);
   endtask

   // edges of the fields, every request and the corner cases
   task automatic test_directed();
      send_request(idl_pkg::REQ_READ_NEXT, '0, '0);            // read on an empty list
      send_request(idl_pkg::REQ_DELETE, '0, '0);               // position zero
      send_request(idl_pkg::REQ_DELETE, 11'd1, '0);            // never handed out
      send_request(idl_pkg::REQ_INS_LEFT, 11'd1, 32'd7);
      send_request(idl_pkg::REQ_INS_HEAD, '0, 32'h8000_0000);
      send_request(idl_pkg::REQ_INS_TAIL, '0, 32'h7FFF_FFFF);
      send_request(idl_pkg::REQ_INS_RIGHT, 11'd1, 32'd0);
      send_request(idl_pkg::REQ_INS_LEFT, 11'd1, 32'hFFFF_FFFF);
      send_request(idl_pkg::REQ_INS_RIGHT, 11'd2, 32'h5555_5555);
      send_request(idl_pkg::REQ_INS_LEFT, 11'd4, 32'hAAAA_AAAA);
      // walk all six elements and off the tail, then once more from the head
      repeat (8) send_request(idl_pkg::REQ_READ_NEXT, '0, '0);
      send_request(idl_pkg::REQ_DELETE, 11'd1, '0);
      send_request(idl_pkg::REQ_DELETE, 11'd1, '0);            // already deleted
      send_request(idl_pkg::REQ_INS_RIGHT, 11'd1, 32'd9);      // beside a deleted element
      send_request(idl_pkg::REQ_DELETE, 11'h7FF, '0);
      send_request(3'd6, 11'h7FF, 32'hFFFF_FFFF);              // unused codes
      send_request(3'd7, '0, 32'h1234_5678);
      send_request(idl_pkg::REQ_READ_NEXT, '0, '0);
   endtask

   task automatic test_random_mix(int count, int insert_weight);
      repeat (count) send_random_request(insert_weight);
   endtask

   // long hold on the result side so the core backs up into its input
   task automatic test_receiver_stall();
      stall_request = 400;
      repeat (16) send_random_request(55);
   endtask

   // sender goes quiet until the core has nothing left in flight
   task automatic test_sender_pause();
      repeat (8) send_random_request(55);
      wait_all_returned();
      repeat (8) send_random_request(55);
   endtask

   // fill every slot, then probe the full store
   task automatic test_store_full();
      while (fill_slot < SLOTS) send_random_request(95);
      send_request(idl_pkg::REQ_INS_HEAD, '0, $urandom);
      send_request(idl_pkg::REQ_INS_RIGHT, pick_position(), $urandom);
      send_request(idl_pkg::REQ_INS_LEFT, '0, $urandom);
      test_random_mix(60, 50);
   endtask

   // result side: random ready, or a forced hold when one is asked for
   always @(posedge clock) begin
      if (stall_request > 0) begin
         stall_left = stall_request;
         stall_request = 0;
      end
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each result beat with the oldest prediction
   always @(posedge clock) begin : check_rsp
      list_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result beat with nothing outstanding: %s %0d value %0d end %0d pos %0d",
                        "status", rsp_status, rsp_read_value, rsp_list_end, rsp_new_position);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status || rsp_read_value !== want.read_value ||
                rsp_list_end !== want.list_end || rsp_new_position !== want.new_position) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("expected status %0d value %0d end %0d pos %0d",
                           want.status, want.read_value, want.list_end, want.new_position);
                  $display("     got status %0d value %0d end %0d pos %0d",
                           rsp_status, rsp_read_value, rsp_list_end, rsp_new_position);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = '0;
      req_position   = '0;
      req_item_value = '0;
      rsp_ready      = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_value[i] = '0;
         prev_slot[i]  = '0;
         succ_slot[i]  = '0;
         slot_live[i]  = 1'b0;
      end
      succ_slot[HEAD_END] = idl_pkg::POS_W'(TAIL_END);
      prev_slot[TAIL_END] = idl_pkg::POS_W'(HEAD_END);
      fill_slot = 2;
      walk_slot = HEAD_END;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // slow sender, very slow receiver
      send_idle_pct = 36;
      recv_idle_pct = 84;
      test_directed();
      test_random_mix(150, 55);
      test_receiver_stall();
      wait_all_returned();

      // roles swapped
      send_idle_pct = 84;
      recv_idle_pct = 36;
      test_random_mix(150, 55);
      test_sender_pause();

      // back to back
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_store_full();

      wait_all_returned();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_outcomes.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
